// File: src/ade_pkg.sv
// ----------------------------------------------------------------------------
// ade_pkg
// Shared types, constants and table builders for the downward expander.
// ----------------------------------------------------------------------------
package ade_pkg;

  localparam int TAB_BITS_MAX    = 12;
  localparam int TAB_ENTRIES_MAX = 1 << TAB_BITS_MAX;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QUEUE_AW        = 2;

  localparam logic [26:0] DB_PER_OCT_Q32 = 27'd101008905;
  localparam logic [21:0] OCT_PER_DB_Q32 = 22'd2786635;
  localparam logic [15:0] DB_FLOOR_MAG   = 16'd51200;

  // register indexes
  localparam logic [2:0] REG_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_RANGE     = 3'd1;
  localparam logic [2:0] REG_SLOPE     = 3'd2;
  localparam logic [2:0] REG_ATTACK    = 3'd3;
  localparam logic [2:0] REG_RELEASE   = 3'd4;

  typedef struct packed {
    logic signed [16:0] threshold_db;
    logic [14:0]        range_limit_db;
    logic [15:0]        slope;
    logic [23:0]        attack_coeff;
    logic [23:0]        release_coeff;
  } ade_cfg_t;

  // classified sample handed from the front to the back
  typedef struct packed {
    logic [23:0] mag;
    logic        neg;
    logic        frame_start;
    logic [14:0] tmag;
  } ade_item_t;

  function automatic logic [15:0] log2_frac_q16(logic [63:0] x30);
    logic [63:0] x;
    logic [15:0] r;
    x = x30;
    r = '0;
    for (int i = 15; i >= 0; i--) begin
      x = (x * x) >> 30;
      if (x >= 64'h8000_0000) begin
        r[i] = 1'b1;
        x = x >> 1;
      end
    end
    return r;
  endfunction

  function automatic logic [TAB_ENTRIES_MAX*16-1:0] log_table(int bits);
    logic [TAB_ENTRIES_MAX*16-1:0] t;
    logic [63:0] x;
    t = '0;
    for (int k = 0; k < (1 << bits); k++) begin
      x = 64'((1 << bits) + k) << (30 - bits);
      t[k*16 +: 16] = log2_frac_q16(x);
    end
    return t;
  endfunction

  function automatic logic [63:0] isqrt64(logic [63:0] v_in);
    logic [63:0] v, res, b;
    v   = v_in;
    res = '0;
    b   = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [TAB_ENTRIES_MAX*31-1:0] exp_table(int bits);
    logic [TAB_ENTRIES_MAX*31-1:0] t;
    logic [63:0] r, e;
    t = '0;
    r = 64'd1 << 29;
    for (int i = 0; i < bits; i++) r = isqrt64(r << 30);
    e = 64'd1 << 30;
    t[30:0] = e[30:0];
    for (int k = 1; k < (1 << bits); k++) begin
      e = (e * r) >> 30;
      t[k*31 +: 31] = e[30:0];
    end
    return t;
  endfunction

endpackage

// File: src/audio_downward_expander.sv
// ----------------------------------------------------------------------------
// audio_downward_expander
// Downward expander with attack/release gain smoothing, one Q1.23 sample per
// transaction.
// ----------------------------------------------------------------------------
//  channel   signals                                      role
//  input     in_valid, in_ready, sample_in, frame_start   sample transaction
//  output    out_valid, out_ready, sample_out, gain_now_db result transaction
//  config    psel, penable, pwrite, paddr, pwdata, prdata, pready  APB registers
//
// The front steps through level, dB multiply, target multiply and push for each
// sample; the back steps through two partial products for the smoothing
// multiply, gain update, log-to-linear multiply, sample multiply and output.
// The back sets sustained throughput; each side takes a new sample only once
// done with the last, and a 4-entry queue lets the front run ahead of the back.
// Reset (rst, synchronous) returns registers to defaults and gain to 0 dB.
// A stalled output holds in its register; the back then stops popping.
// ----------------------------------------------------------------------------
module audio_downward_expander import ade_pkg::*; #(
  parameter int LOG_TABLE_BITS = 8,
  parameter int EXP_TABLE_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] sample_in,
  input  logic               frame_start,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] sample_out,
  output logic signed [15:0] gain_now_db
);

  ade_cfg_t  cfg;
  ade_item_t push_item, pop_item;
  logic      q_push, q_pop, q_full, q_empty;

  // settings
  ade_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg
  );

  // level detection and target attenuation
  ade_front #(.LOG_TABLE_BITS(LOG_TABLE_BITS)) u_front (
    .clk, .rst, .cfg, .sample_in, .frame_start, .in_valid, .in_ready,
    .q_full, .q_push, .q_item(push_item)
  );

  // decouple classification from gain processing
  ade_fifo u_fifo (
    .clk, .rst, .push(q_push), .wr_item(push_item), .pop(q_pop),
    .rd_item(pop_item), .full(q_full), .empty(q_empty)
  );

  // smoothing and sample scaling
  ade_back #(.EXP_TABLE_BITS(EXP_TABLE_BITS)) u_back (
    .clk, .rst, .cfg, .q_empty, .q_item(pop_item), .q_pop,
    .sample_out, .gain_now_db, .out_valid, .out_ready
  );

endmodule

// File: src/ade_regs.sv
// ----------------------------------------------------------------------------
// ade_regs
// APB register file holding the expander settings.
// ----------------------------------------------------------------------------
module ade_regs import ade_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output ade_cfg_t    cfg
);

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold_db   <= -17'sd10240;
      cfg.range_limit_db <= 15'd5120;
      cfg.slope          <= 16'd32768;
      cfg.attack_coeff   <= 24'd38001;
      cfg.release_coeff  <= 24'd3804;
    end else if (wr_en) begin
      case (idx)
        REG_THRESHOLD: cfg.threshold_db   <= pwdata[16:0];
        REG_RANGE:     cfg.range_limit_db <= pwdata[14:0];
        REG_SLOPE:     cfg.slope          <= pwdata[15:0];
        REG_ATTACK:    cfg.attack_coeff   <= pwdata[23:0];
        REG_RELEASE:   cfg.release_coeff  <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_THRESHOLD: prdata = {15'd0, cfg.threshold_db};
      REG_RANGE:     prdata = {17'd0, cfg.range_limit_db};
      REG_SLOPE:     prdata = {16'd0, cfg.slope};
      REG_ATTACK:    prdata = {8'd0, cfg.attack_coeff};
      REG_RELEASE:   prdata = {8'd0, cfg.release_coeff};
      default:       prdata = 32'd0;
    endcase
  end

endmodule

// File: src/ade_front.sv
// ----------------------------------------------------------------------------
// ade_front
// Accept a sample, measure its level in dB and derive the target attenuation.
// ----------------------------------------------------------------------------
module ade_front import ade_pkg::*; #(
  parameter int LOG_TABLE_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  ade_cfg_t           cfg,
  input  logic signed [23:0] sample_in,
  input  logic               frame_start,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               q_full,
  output logic               q_push,
  output ade_item_t          q_item
);

  localparam logic [TAB_ENTRIES_MAX*16-1:0] LOG_TAB = log_table(LOG_TABLE_BITS);

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_LVL  = 5'b00010,
    F_DB   = 5'b00100,
    F_TGT  = 5'b01000,
    F_PUSH = 5'b10000
  } front_state_t;

  front_state_t state, state_next;

  logic [23:0] mag;
  logic        neg;
  logic        fs;
  logic        zero;
  logic [20:0] negl;
  logic [15:0] db_mag;
  logic        below;
  logic [32:0] tprod;

  logic [4:0]                p;
  logic [4:0]                sh;
  logic [23:0]               norm;
  logic [LOG_TABLE_BITS-1:0] k;
  logic [15:0]               tab;
  logic [47:0]               dprod;
  logic signed [17:0]        db_s;
  logic [16:0]               under;
  logic [17:0]               tm;
  logic [14:0]               tmag;

  // leading one and table lookup
  always_comb begin
    p = 5'd0;
    for (int b = 0; b < 24; b++) begin
      if (mag[b]) p = 5'(b);
    end
    sh   = 5'd23 - p;
    norm = mag << sh;
    k    = norm[22 -: LOG_TABLE_BITS];
    tab  = LOG_TAB[16*k +: 16];
  end

  assign dprod = 48'(negl) * 48'(DB_PER_OCT_Q32) + 48'h0000_8000_0000;
  assign db_s  = -$signed({2'b00, db_mag});
  assign under = 17'($signed({cfg.threshold_db[16], cfg.threshold_db}) - db_s);
  assign tm    = 18'((34'(tprod) + 34'd32768) >> 16);
  assign tmag  = !below ? 15'd0 :
                 (tm > 18'(cfg.range_limit_db)) ? cfg.range_limit_db : tm[14:0];

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: if (in_valid) state_next = F_LVL;
      F_LVL:  state_next = F_DB;
      F_DB:   state_next = F_TGT;
      F_TGT:  state_next = F_PUSH;
      F_PUSH: if (!q_full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= F_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        neg  <= sample_in[23];
        mag  <= sample_in[23] ? 24'(-sample_in) : sample_in;
        fs   <= frame_start;
      end
      F_LVL: begin
        zero <= (mag == 24'd0);
        negl <= {sh, 16'd0} - 21'(tab);
      end
      F_DB: db_mag <= zero ? DB_FLOOR_MAG : dprod[47:32];
      F_TGT: begin
        below <= db_s < $signed({cfg.threshold_db[16], cfg.threshold_db});
        tprod <= 33'(under) * 33'(cfg.slope);
      end
      default: ;
    endcase
  end

  assign in_ready = (state == F_IDLE);
  assign q_push   = (state == F_PUSH) && !q_full;
  assign q_item   = '{mag: mag, neg: neg, frame_start: fs, tmag: tmag};

endmodule

// File: src/ade_fifo.sv
// ----------------------------------------------------------------------------
// ade_fifo
// Short queue of classified samples between front and back.
// ----------------------------------------------------------------------------
module ade_fifo import ade_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  ade_item_t wr_item,
  input  logic      pop,
  output ade_item_t rd_item,
  output logic      full,
  output logic      empty
);

  ade_item_t          mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_AW:0]   count;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
    end
  end

  assign rd_item = mem[rd_ptr];
  assign full    = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);

endmodule

// File: src/ade_back.sv
// ----------------------------------------------------------------------------
// ade_back
// Smooth the gain toward the target and scale the sample.
// ----------------------------------------------------------------------------
module ade_back import ade_pkg::*; #(
  parameter int EXP_TABLE_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  ade_cfg_t           cfg,
  input  logic               q_empty,
  input  ade_item_t          q_item,
  output logic               q_pop,
  output logic signed [23:0] sample_out,
  output logic signed [15:0] gain_now_db,
  output logic               out_valid,
  input  logic               out_ready
);

  localparam logic [TAB_ENTRIES_MAX*31-1:0] EXP_TAB = exp_table(EXP_TABLE_BITS);

  typedef enum logic [6:0] {
    B_IDLE = 7'b0000001,
    B_LO   = 7'b0000010,
    B_HI   = 7'b0000100,
    B_UPD  = 7'b0001000,
    B_Q    = 7'b0010000,
    B_EXP  = 7'b0100000,
    B_OUT  = 7'b1000000
  } back_state_t;

  back_state_t state, state_next;

  ade_item_t   cur;
  logic [38:0] gmag;        // magnitude of the smoothed gain (gain <= 0)
  logic        up;          // target attenuation deeper than current
  logic [18:0] dmag_hi;
  logic [23:0] coeff;
  logic [43:0] plo;
  logic [42:0] phi;
  logic [14:0] att;
  logic [20:0] q;
  logic [54:0] prod;

  logic [38:0]               tq;
  logic [38:0]               dmag;
  logic [62:0]               step_sum;
  logic [39:0]               att_sum;
  logic [36:0]               qprod;
  logic [EXP_TABLE_BITS-1:0] j;
  logic [30:0]               etab;
  logic [4:0]                ip;
  logic [55:0]               rsum;
  logic [23:0]               ymag;
  logic                      load_out;

  assign tq       = {cur.tmag, 24'd0};
  assign dmag     = (tq > gmag) ? tq - gmag : gmag - tq;
  assign step_sum = {phi, 20'd0} + 63'(plo);
  assign att_sum  = 40'(gmag) + 40'h00_0080_0000;
  // take the rounded attenuation straight from the updated gain
  assign qprod    = 37'(att_sum[38:24]) * 37'(OCT_PER_DB_Q32) + 37'd32768;
  assign j        = q[15 -: EXP_TABLE_BITS];
  assign etab     = EXP_TAB[31*j +: 31];
  assign ip       = q[20:16];
  assign rsum     = 56'(prod) + (56'd1 << (6'd29 + 6'(ip)));
  assign ymag     = 24'(rsum >> (6'd30 + 6'(ip)));
  assign load_out = (state == B_OUT) && (!out_valid || out_ready);
  assign q_pop    = (state == B_IDLE) && !q_empty;

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: if (!q_empty) state_next = B_LO;
      B_LO:   state_next = B_HI;
      B_HI:   state_next = B_UPD;
      B_UPD:  state_next = B_Q;
      B_Q:    state_next = B_EXP;
      B_EXP:  state_next = B_OUT;
      B_OUT:  if (load_out) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      gmag      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (q_pop && q_item.frame_start) gmag <= '0;
      if (state == B_UPD) begin
        gmag <= up ? gmag + step_sum[62:24] : gmag - step_sum[62:24];
      end
      if (load_out)            out_valid <= 1'b1;
      else if (out_ready)      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: if (q_pop) cur <= q_item;
      B_LO: begin
        up      <= tq > gmag;
        coeff   <= (tq > gmag) ? cfg.attack_coeff : cfg.release_coeff;
        dmag_hi <= dmag[38:20];
        plo     <= 44'(dmag[19:0]) * 44'((tq > gmag) ? cfg.attack_coeff
                                                     : cfg.release_coeff);
      end
      B_HI:  phi <= 43'(dmag_hi) * 43'(coeff);
      B_Q: begin
        att <= att_sum[38:24];
        q   <= qprod[36:16];
      end
      B_EXP: prod <= 55'(cur.mag) * 55'(etab);
      B_OUT: if (load_out) begin
        sample_out  <= cur.neg ? 24'(-ymag) : ymag;
        gain_now_db <= 16'(-{1'b0, att});
      end
      default: ;
    endcase
  end

endmodule
